// ===== sv/sync_frame_sum_checker_assert.svh =====
// Assertion macros for the frame sum checker.
`ifndef SYNC_FRAME_SUM_CHECKER_ASSERT_SVH
`define SYNC_FRAME_SUM_CHECKER_ASSERT_SVH

`ifndef SYNTH

`define SFSC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define SFSC_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SFSC_ASSERT_IMP(lbl, ante, cons, msg)

`define SFSC_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== sv/sfsc_pkg.sv =====
`default_nettype none

package sfsc_pkg;

   localparam int BUFFER_BYTES = 64;
   localparam int BUF_AW       = $clog2(BUFFER_BYTES);
   localparam int BYTE_W       = 8;
   localparam int LEN_W        = 6;
   localparam int SYNC_COUNT   = 2;
   localparam int LEN_MIN      = 4;
   localparam int LEN_MAX      = 62;

   localparam logic [BUF_AW-1:0] OVERRUN_IDX = BUF_AW'(BUFFER_BYTES - 2);

   localparam int CSR_AW = 2;

   typedef enum logic [CSR_AW-1:0] {
      REG_SYNC_FIRST   = 2'd0,
      REG_SYNC_SECOND  = 2'd1,
      REG_FRAME_LENGTH = 2'd2
   } csr_reg_type;

   typedef enum logic [1:0] {
      PH_HUNT1 = 2'd0,
      PH_HUNT2 = 2'd1,
      PH_DATA  = 2'd2,
      PH_SUM   = 2'd3
   } phase_type;

   function automatic logic [LEN_W-1:0] len_minus_one(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] clamped;
      clamped = len;
      if (len < LEN_W'(LEN_MIN)) clamped = LEN_W'(LEN_MIN);
      if (len > LEN_W'(LEN_MAX)) clamped = LEN_W'(LEN_MAX);
      return clamped - LEN_W'(1);
   endfunction

endpackage

`default_nettype wire

// ===== sv/sfsc_ram.sv =====
`default_nettype none

module sfsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/sync_frame_sum_checker.sv =====
// Two-sync-byte frame checker with an 8-bit additive checksum. It accepts a
// received byte while req_valid is high and req_stall is low, and writes frame
// bytes to a 64-byte frame store. When the checksum byte matches the wrapping
// sum of all earlier frame bytes, the whole frame, checksum included, is read
// back out of the store and sent with rsp_frame_last on the checksum byte; a
// failed frame sends nothing. Each readout byte takes a store read, then an
// output register load, and waits while rsp_stall is held; req_stall stays high
// until the last byte has been read from the store, so input is held off during
// readout. The frame store needs no clearing after reset. frame_length is
// sampled when the second sync byte arrives and saturates to 4..62.
`default_nettype none

module sync_frame_sum_checker
   import sfsc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [BYTE_W-1:0]   req_rx_byte,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic      [BYTE_W-1:0]   rsp_frame_byte,
   output logic                     rsp_frame_last,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [CSR_AW-1:0]   csr_index,
   input  wire logic [BYTE_W-1:0]   csr_data
);

`include "sync_frame_sum_checker_assert.svh"

   logic [BYTE_W-1:0] sync_first_ff;
   logic [BYTE_W-1:0] sync_second_ff;
   logic [LEN_W-1:0]  frame_length_ff;

   phase_type         phase_ff, phase_in;
   logic [BUF_AW-1:0] wi_ff, wi_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [LEN_W-1:0]  len_m1_ff, len_m1_in;

   logic              req_fire;
   logic              mem_we;
   logic [BUF_AW-1:0] mem_waddr;
   logic [BYTE_W-1:0] mem_rdata;
   logic              start_rd;

   logic              rd_active_ff;
   logic [BUF_AW-1:0] rd_addr_ff;
   logic [BUF_AW-1:0] rd_end_ff;
   logic              rd_pend_ff;
   logic              rd_pend_last_ff;
   logic              rd_issue;
   logic              rd_at_end;

   logic              out_valid_ff;
   logic [BYTE_W-1:0] out_byte_ff;
   logic              out_last_ff;

   assign csr_ready = 1'b1;
   assign req_stall = rd_active_ff;
   assign req_fire  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff   <= BYTE_W'(170);
         sync_second_ff  <= BYTE_W'(85);
         frame_length_ff <= LEN_W'(16);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_SYNC_FIRST:   sync_first_ff   <= csr_data;
            REG_SYNC_SECOND:  sync_second_ff  <= csr_data;
            REG_FRAME_LENGTH: frame_length_ff <= csr_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT1;
         wi_ff     <= '0;
         sum_ff    <= '0;
         len_m1_ff <= LEN_W'(15);
      end else begin
         phase_ff  <= phase_in;
         wi_ff     <= wi_in;
         sum_ff    <= sum_in;
         len_m1_ff <= len_m1_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      wi_in     = wi_ff;
      sum_in    = sum_ff;
      len_m1_in = len_m1_ff;
      mem_we    = 1'b0;
      mem_waddr = wi_ff;
      start_rd  = 1'b0;
      if (req_fire) begin
         unique case (phase_ff)
            PH_HUNT1: begin
               wi_in     = '0;
               sum_in    = req_rx_byte;
               mem_we    = 1'b1;
               mem_waddr = '0;
               if (req_rx_byte == sync_first_ff) begin
                  phase_in = PH_HUNT2;
               end
            end
            PH_HUNT2: begin
               if (req_rx_byte == sync_second_ff) begin
                  len_m1_in = len_minus_one(frame_length_ff);
                  wi_in     = BUF_AW'(SYNC_COUNT);
                  sum_in    = sum_ff + req_rx_byte;
                  mem_we    = 1'b1;
                  mem_waddr = BUF_AW'(1);
                  phase_in  = PH_DATA;
               end else begin
                  phase_in = PH_HUNT1;
               end
            end
            PH_DATA: begin
               if (wi_ff >= OVERRUN_IDX) begin
                  phase_in = PH_HUNT1;
               end else begin
                  mem_we = 1'b1;
                  wi_in  = wi_ff + BUF_AW'(1);
                  sum_in = sum_ff + req_rx_byte;
                  if (16'(wi_ff) + 16'd1 >= 16'(len_m1_ff)) begin
                     phase_in = PH_SUM;
                  end
               end
            end
            PH_SUM: begin
               mem_we   = 1'b1;
               start_rd = (req_rx_byte == sum_ff);
               phase_in = PH_HUNT1;
            end
            default: phase_in = PH_HUNT1;
         endcase
      end
   end

   assign rd_at_end = (rd_addr_ff == rd_end_ff);
   assign rd_issue  = rd_active_ff && !rd_pend_ff && (!out_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_active_ff    <= 1'b0;
         rd_addr_ff      <= '0;
         rd_end_ff       <= '0;
         rd_pend_ff      <= 1'b0;
         rd_pend_last_ff <= 1'b0;
      end else begin
         if (start_rd) begin
            rd_active_ff <= 1'b1;
            rd_addr_ff   <= '0;
            rd_end_ff    <= wi_ff;
         end else if (rd_issue) begin
            rd_addr_ff <= rd_addr_ff + BUF_AW'(1);
            if (rd_at_end) begin
               rd_active_ff <= 1'b0;
            end
         end
         rd_pend_ff      <= rd_issue;
         rd_pend_last_ff <= rd_issue && rd_at_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         out_last_ff  <= 1'b0;
      end else if (rd_pend_ff) begin
         out_valid_ff <= 1'b1;
         out_last_ff  <= rd_pend_last_ff;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_pend_ff) begin
         out_byte_ff <= mem_rdata;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_frame_byte = out_byte_ff;
   assign rsp_frame_last = out_last_ff;

   sfsc_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(BUFFER_BYTES)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (req_rx_byte),
      .rd_en   (rd_issue),
      .rd_addr (rd_addr_ff),
      .rd_data (mem_rdata)
   );

   `SFSC_ASSERT_IMP(a_no_write_in_readout, rd_active_ff, !mem_we, "store written during readout")
   `SFSC_ASSERT_NXT(a_issue_loads_out, rd_issue, rd_pend_ff, "store read not followed by load")
   `SFSC_ASSERT_IMP(a_no_overwrite_out, rd_pend_ff, !out_valid_ff, "output register overwritten")
   `SFSC_ASSERT_IMP(a_no_start_in_readout, start_rd, !rd_active_ff, "frame start during readout")

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
module testbench;
   import sfsc_pkg::*;

   localparam int SETTLE_CYCLES  = 2 * LEN_MAX + 20;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES         = 9;
   localparam int PLAN_ROWS      = 30;

   typedef enum logic {ROW_BYTE, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      csr_reg_type       csr_sel;
      logic [BYTE_W-1:0] value;
      logic              typed;
      logic              keep;
      logic              last;
   } plan_row_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } frame_beat_type;

   logic                clock;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_stall;
   logic [BYTE_W-1:0]   req_rx_byte    = '0;
   logic                rsp_valid;
   logic                rsp_stall      = 1'b0;
   logic [BYTE_W-1:0]   rsp_frame_byte;
   logic                rsp_frame_last;
   logic                csr_valid      = 1'b0;
   logic                csr_ready;
   logic [CSR_AW-1:0]   csr_index      = '0;
   logic [BYTE_W-1:0]   csr_data       = '0;

   sync_frame_sum_checker DUT (.*);

   // directed plan: typed rows carry their own expectation, the rest go to the predictor
   plan_row_type directed_plan [PLAN_ROWS] = '{
      '{ROW_BYTE, REG_SYNC_FIRST,   8'hAA, 1'b1, 1'b1, 1'b0},
      '{ROW_BYTE, REG_SYNC_FIRST,   8'h55, 1'b1, 1'b1, 1'b0},
      '{ROW_BYTE, REG_SYNC_FIRST,   8'h00, 1'b1, 1'b1, 1'b0},
      '{ROW_BYTE, REG_SYNC_FIRST,   8'h00, 1'b1, 1'b1, 1'b0},
      '{ROW_BYTE, REG_SYNC_FIRST,   8'h00, 1'b1, 1'b1, 1'b0},
      '{ROW_BYTE, REG_SYNC_FIRST,   8'h00, 1'b1, 1'b1, 1'b0},
      '{ROW_BYTE, REG_SYNC_FIRST,   8'h00, 1'b1, 1'b1, 1'b0},
      '{ROW_BYTE, REG_SYNC_FIRST,   8'h00, 1'b1, 1'b1, 1'b0},
      '{ROW_BYTE, REG_SYNC_FIRST,   8'h00, 1'b1, 1'b1, 1'b0},
      '{ROW_BYTE, REG_SYNC_FIRST,   8'h00, 1'b1, 1'b1, 1'b0},
      '{ROW_BYTE, REG_SYNC_FIRST,   8'h00, 1'b1, 1'b1, 1'b0},
      '{ROW_BYTE, REG_SYNC_FIRST,   8'h00, 1'b1, 1'b1, 1'b0},
      '{ROW_BYTE, REG_SYNC_FIRST,   8'h00, 1'b1, 1'b1, 1'b0},
      '{ROW_BYTE, REG_SYNC_FIRST,   8'h00, 1'b1, 1'b1, 1'b0},
      '{ROW_BYTE, REG_SYNC_FIRST,   8'h00, 1'b1, 1'b1, 1'b0},
      '{ROW_BYTE, REG_SYNC_FIRST,   8'hFF, 1'b1, 1'b1, 1'b1},
      '{ROW_CSR,  REG_FRAME_LENGTH, 8'h03, 1'b0, 1'b0, 1'b0},
      '{ROW_CSR,  REG_SYNC_FIRST,   8'h00, 1'b0, 1'b0, 1'b0},
      '{ROW_CSR,  REG_SYNC_SECOND,  8'hFF, 1'b0, 1'b0, 1'b0},
      // wrong second sync: dropped byte must not restart the frame
      '{ROW_BYTE, REG_SYNC_FIRST,   8'h00, 1'b1, 1'b0, 1'b0},
      '{ROW_BYTE, REG_SYNC_FIRST,   8'h00, 1'b1, 1'b0, 1'b0},
      '{ROW_BYTE, REG_SYNC_FIRST,   8'hFF, 1'b1, 1'b0, 1'b0},
      '{ROW_BYTE, REG_SYNC_FIRST,   8'h00, 1'b1, 1'b1, 1'b0},
      '{ROW_BYTE, REG_SYNC_FIRST,   8'hFF, 1'b1, 1'b1, 1'b0},
      '{ROW_BYTE, REG_SYNC_FIRST,   8'h80, 1'b1, 1'b1, 1'b0},
      '{ROW_BYTE, REG_SYNC_FIRST,   8'h7F, 1'b1, 1'b1, 1'b1},
      // bad checksum
      '{ROW_BYTE, REG_SYNC_FIRST,   8'h00, 1'b0, 1'b0, 1'b0},
      '{ROW_BYTE, REG_SYNC_FIRST,   8'hFF, 1'b0, 1'b0, 1'b0},
      '{ROW_BYTE, REG_SYNC_FIRST,   8'h80, 1'b0, 1'b0, 1'b0},
      '{ROW_BYTE, REG_SYNC_FIRST,   8'h7E, 1'b0, 1'b0, 1'b0}
   };

   logic [BYTE_W-1:0] cfg_sync_first   = 8'hAA;
   logic [BYTE_W-1:0] cfg_sync_second  = 8'h55;
   int                cfg_frame_length = 16;

   phase_type         parse_phase   = PH_HUNT1;
   int                parse_index   = 0;
   logic [BYTE_W-1:0] parse_sum     = '0;
   int                parse_length  = 16;
   logic [BYTE_W-1:0] parse_store [BUFFER_BYTES];

   frame_beat_type    expected_beats [$];
   frame_beat_type    head_beat;
   int                mismatches    = 0;
   int                sent_items    = 0;
   int                quiet_cycles  = 0;
   bit                calm          = 1'b0;
   bit                long_hold_req = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int saturated_length(input int len);
      if (len < LEN_MIN) return LEN_MIN;
      if (len > LEN_MAX) return LEN_MAX;
      return len;
   endfunction

   task automatic predict_frame_bytes(input logic [BYTE_W-1:0] b, input bit record);
      int i;
      case (parse_phase)
         PH_HUNT1: begin
            parse_index    = 0;
            parse_sum      = b;
            parse_store[0] = b;
            if (b == cfg_sync_first) parse_phase = PH_HUNT2;
         end
         PH_HUNT2: begin
            if (b == cfg_sync_second) begin
               parse_length   = saturated_length(cfg_frame_length);
               parse_index    = SYNC_COUNT;
               parse_sum      = parse_sum + b;
               parse_store[1] = b;
               parse_phase    = PH_DATA;
            end else begin
               parse_phase = PH_HUNT1;
            end
         end
         PH_DATA: begin
            if (parse_index >= BUFFER_BYTES - 2) begin
               parse_phase = PH_HUNT1;
            end else begin
               parse_store[parse_index] = b;
               parse_index++;
               parse_sum = parse_sum + b;
               if (parse_index >= parse_length - 1) parse_phase = PH_SUM;
            end
         end
         default: begin
            if (parse_index < BUFFER_BYTES) begin
               parse_store[parse_index] = b;
               if (b == parse_sum && record) begin
                  for (i = 0; i <= parse_index; i++)
                     expected_beats.push_back(
                        frame_beat_type'{parse_store[i], i == parse_index});
               end
            end
            parse_phase = PH_HUNT1;
         end
      endcase
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] b, input bit record);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      predict_frame_bytes(b, record);
      sent_items++;
   endtask

   task automatic drain_results(input int extra);
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_beats.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_csr(input csr_reg_type sel, input logic [BYTE_W-1:0] data);
      drain_results(SETTLE_CYCLES);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (sel)
         REG_SYNC_FIRST:   cfg_sync_first   = data;
         REG_SYNC_SECOND:  cfg_sync_second  = data;
         REG_FRAME_LENGTH: cfg_frame_length = int'(data[LEN_W-1:0]);
         default: ;
      endcase
   endtask

   task automatic configure(input logic [BYTE_W-1:0] sf, input logic [BYTE_W-1:0] ss,
                            input logic [BYTE_W-1:0] len);
      write_csr(REG_SYNC_FIRST, sf);
      write_csr(REG_SYNC_SECOND, ss);
      write_csr(REG_FRAME_LENGTH, len);
   endtask

   task automatic send_frame(input bit good);
      int                n;
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] b;
      n   = saturated_length(cfg_frame_length);
      sum = cfg_sync_first + cfg_sync_second;
      send_byte(cfg_sync_first, 1'b1);
      send_byte(cfg_sync_second, 1'b1);
      repeat (n - 3) begin
         b   = 8'($urandom);
         sum = sum + b;
         send_byte(b, 1'b1);
      end
      if (!good) sum = sum + 8'($urandom_range(1, 255));
      send_byte(sum, 1'b1);
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_req = 1'b0;
            rsp_stall <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual byte %h last %b",
                     $time, rsp_frame_byte, rsp_frame_last);
            mismatches++;
         end else begin
            head_beat = expected_beats.pop_front();
            if (rsp_frame_byte !== head_beat.data) begin
               $display("%0t: frame_byte expected %h actual %h",
                        $time, head_beat.data, rsp_frame_byte);
               mismatches++;
            end
            if (rsp_frame_last !== head_beat.last) begin
               $display("%0t: frame_last expected %b actual %b",
                        $time, head_beat.last, rsp_frame_last);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int                r;
      int                p;
      int                budget;
      int                phase_start;
      logic [BYTE_W-1:0] sf;
      logic [BYTE_W-1:0] b;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < PLAN_ROWS; r++) begin
         if (directed_plan[r].kind == ROW_CSR) begin
            write_csr(directed_plan[r].csr_sel, directed_plan[r].value);
         end else begin
            send_byte(directed_plan[r].value, !directed_plan[r].typed);
            if (directed_plan[r].typed && directed_plan[r].keep)
               expected_beats.push_back(frame_beat_type'{directed_plan[r].value,
                                                         directed_plan[r].last});
         end
      end

      for (p = 0; p < PHASES; p++) begin
         budget = 30;
         case (p)
            0: begin
               configure(8'($urandom), 8'($urandom), 8'd63);
               budget = 100;
            end
            1: begin
               configure(8'hFF, 8'h00, 8'hC4);
               budget = 50;
            end
            2: begin
               configure(8'($urandom), 8'($urandom), 8'h81);
               budget = 45;
            end
            default: begin
               sf = 8'($urandom);
               b  = ($urandom_range(0, 5) == 0) ? sf : 8'($urandom);
               configure(sf, b, {2'($urandom), 6'($urandom_range(4, 12))});
            end
         endcase
         calm = (p == PHASES - 1) || ($urandom_range(0, 3) == 0);
         phase_start = sent_items;

         // fill the block behind a long output hold
         if (p == 0) begin
            send_frame(1'b1);
            long_hold_req = 1'b1;
            send_frame(1'b1);
         end
         if (p == 2) begin
            send_frame(1'b1);
            drain_results(0);
         end

         while (sent_items - phase_start < budget) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               send_frame(1'b1);
            end else if (r < 80) begin
               send_frame(1'b0);
            end else if (r < 88) begin
               send_byte(cfg_sync_first, 1'b1);
               b = 8'($urandom);
               if (b == cfg_sync_second) b = ~b;
               send_byte(b, 1'b1);
            end else begin
               repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b1);
            end
         end
      end

      drain_results(SETTLE_CYCLES);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/sfsc_pkg.sv
sv/sfsc_ram.sv
sv/sync_frame_sum_checker.sv
verif/testbench.sv
